### rtl/mhfs_pkg.sv
// mhfs_pkg: types, character codes and helpers for the mail header field splitter
// no dependencies; used by every other file of the block except the two interfaces
package mhfs_pkg;

  // character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    K_TAG    = 2'd0,
    K_BODY   = 2'd1,
    K_END    = 2'd2,
    K_STATUS = 2'd3
  } kind_t;

  // line parser state
  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_TAG   = 4'b0010,
    PH_COLON = 4'b0100,
    PH_BODY  = 4'b1000
  } phase_t;

  // decoupling queue between parser and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // one result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       status;
    logic       last;
  } result_t;

  // up to two results caused by one input item
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic result_t mk_result(kind_t kind, logic [7:0] b, logic st, logic lst);
    result_t r;
    r.kind     = kind;
    r.out_byte = b;
    r.status   = st;
    r.last     = lst;
    return r;
  endfunction

endpackage

### rtl/mhfs_in_if.sv
// mhfs_in_if: valid/ready channel carrying one header input item
// depends on nothing
interface mhfs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink   (input valid, input op, input in_byte, output ready);
endinterface

### rtl/mhfs_out_if.sv
// mhfs_out_if: valid/ready channel carrying one result item
// depends on nothing
interface mhfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       status;
  logic       last;

  modport source (output valid, output kind, output out_byte, output status, output last,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input status, input last,
                  output ready);
endinterface

### rtl/mhfs_front.sv
// mhfs_front: accepts header items, tracks line phase and builds result entries
// depends on mhfs_pkg and mhfs_in_if
module mhfs_front (
  input  logic               clk,
  input  logic               rst,
  mhfs_in_if.sink            hdr_in,
  output logic               push,
  output mhfs_pkg::entry_t   push_entry,
  input  logic               push_ready
);

  mhfs_pkg::phase_t phase, phase_next;
  logic             field_open, open_next;
  logic             format_error, err_next;
  logic             has_res;
  logic             end_err;
  logic [7:0]       c;

  assign hdr_in.ready = push_ready;
  assign c = hdr_in.in_byte;

  // per-item classification and next state
  always_comb begin
    phase_next = phase;
    open_next  = field_open;
    err_next   = format_error;
    has_res    = 1'b0;
    end_err    = 1'b0;
    push_entry = '0;
    if (hdr_in.op == mhfs_pkg::OP_END) begin
      end_err = format_error | (phase == mhfs_pkg::PH_TAG) | ~field_open;
      has_res = 1'b1;
      if (!end_err) begin
        push_entry.two = 1'b1;
        push_entry.r0  = mhfs_pkg::mk_result(mhfs_pkg::K_END, 8'h00, 1'b0, 1'b0);
        push_entry.r1  = mhfs_pkg::mk_result(mhfs_pkg::K_STATUS, 8'h00, 1'b0, 1'b1);
      end else begin
        push_entry.r0  = mhfs_pkg::mk_result(mhfs_pkg::K_STATUS, 8'h00, 1'b1, 1'b1);
      end
      phase_next = mhfs_pkg::PH_START;
      open_next  = 1'b0;
      err_next   = 1'b0;
    end else if (!format_error && c != mhfs_pkg::CH_CR) begin
      unique case (phase)
        mhfs_pkg::PH_START: begin
          if (c == mhfs_pkg::CH_LF) begin
            // empty line skipped
          end else if (c == mhfs_pkg::CH_SPACE || c == mhfs_pkg::CH_TAB) begin
            if (!field_open) begin
              err_next = 1'b1;
            end else begin
              has_res        = 1'b1;
              push_entry.two = 1'b1;
              push_entry.r0  = mhfs_pkg::mk_result(mhfs_pkg::K_BODY, mhfs_pkg::CH_LF,
                                                   1'b0, 1'b0);
              push_entry.r1  = mhfs_pkg::mk_result(mhfs_pkg::K_BODY, c, 1'b0, 1'b1);
              phase_next     = mhfs_pkg::PH_BODY;
            end
          end else if (c == mhfs_pkg::CH_COLON) begin
            err_next = 1'b1;
          end else begin
            has_res    = 1'b1;
            phase_next = mhfs_pkg::PH_TAG;
            if (field_open) begin
              push_entry.two = 1'b1;
              push_entry.r0  = mhfs_pkg::mk_result(mhfs_pkg::K_END, 8'h00, 1'b0, 1'b0);
              push_entry.r1  = mhfs_pkg::mk_result(mhfs_pkg::K_TAG, c, 1'b0, 1'b1);
              open_next      = 1'b0;
            end else begin
              push_entry.r0  = mhfs_pkg::mk_result(mhfs_pkg::K_TAG, c, 1'b0, 1'b1);
            end
          end
        end
        mhfs_pkg::PH_TAG: begin
          if (c == mhfs_pkg::CH_LF) begin
            err_next = 1'b1;
          end else if (c == mhfs_pkg::CH_COLON) begin
            open_next  = 1'b1;
            phase_next = mhfs_pkg::PH_COLON;
          end else begin
            has_res       = 1'b1;
            push_entry.r0 = mhfs_pkg::mk_result(mhfs_pkg::K_TAG, c, 1'b0, 1'b1);
          end
        end
        mhfs_pkg::PH_COLON: begin
          if (c == mhfs_pkg::CH_LF) begin
            phase_next = mhfs_pkg::PH_START;
          end else begin
            // one space after the colon is dropped
            if (c != mhfs_pkg::CH_SPACE) begin
              has_res       = 1'b1;
              push_entry.r0 = mhfs_pkg::mk_result(mhfs_pkg::K_BODY, c, 1'b0, 1'b1);
            end
            phase_next = mhfs_pkg::PH_BODY;
          end
        end
        mhfs_pkg::PH_BODY: begin
          if (c == mhfs_pkg::CH_LF) begin
            phase_next = mhfs_pkg::PH_START;
          end else begin
            has_res       = 1'b1;
            push_entry.r0 = mhfs_pkg::mk_result(mhfs_pkg::K_BODY, c, 1'b0, 1'b1);
          end
        end
        default: begin
          phase_next = mhfs_pkg::PH_START;
        end
      endcase
    end
  end

  assign push = hdr_in.valid & push_ready & has_res;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mhfs_pkg::PH_START;
      field_open   <= 1'b0;
      format_error <= 1'b0;
    end else if (hdr_in.valid && push_ready) begin
      phase        <= phase_next;
      field_open   <= open_next;
      format_error <= err_next;
    end
  end

endmodule

### rtl/mhfs_queue.sv
// mhfs_queue: short fifo of result entries between parser and output stage
// depends on mhfs_pkg
module mhfs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mhfs_pkg::entry_t push_entry,
  output logic             push_ready,
  output logic             pop_valid,
  output mhfs_pkg::entry_t pop_entry,
  input  logic             pop
);

  mhfs_pkg::entry_t        store [mhfs_pkg::QDEPTH];
  logic [mhfs_pkg::QAW-1:0] wr_ptr;
  logic [mhfs_pkg::QAW-1:0] rd_ptr;
  logic [mhfs_pkg::QAW:0]   count;
  logic                     do_push;
  logic                     do_pop;

  assign push_ready = (count != (mhfs_pkg::QAW+1)'(mhfs_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = store[rd_ptr];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/mhfs_back.sv
// mhfs_back: output stage that sends the one or two results of each entry
// depends on mhfs_pkg and mhfs_out_if
module mhfs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  input  mhfs_pkg::entry_t pop_entry,
  output logic             pop,
  mhfs_out_if.source       res_out
);

  logic              out_valid;
  mhfs_pkg::result_t out_res;
  logic              pend;
  mhfs_pkg::result_t second;
  logic              load;

  assign load = ~out_valid | res_out.ready;
  assign pop  = load & ~pend & pop_valid;

  assign res_out.valid    = out_valid;
  assign res_out.kind     = out_res.kind;
  assign res_out.out_byte = out_res.out_byte;
  assign res_out.status   = out_res.status;
  assign res_out.last     = out_res.last;

  // output register and held second result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (pop_valid) begin
        out_valid <= 1'b1;
        pend      <= pop_entry.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        out_res <= second;
      end else if (pop_valid) begin
        out_res <= pop_entry.r0;
        second  <= pop_entry.r1;
      end
    end
  end

endmodule

### rtl/mail_header_field_splitter.sv
// Mail header field splitter: takes header text one byte per item and sends
// tag bytes, body bytes, field-end marks and a final status. An input item is
// accepted in every cycle while the four-entry queue between the line parser
// and the output stage has room. Each item causes zero, one or two results,
// and the output stage sends one result per cycle while the receiver is ready,
// so the queue absorbs the difference when items bring two results. The first
// result of an item is written into the queue and then into the output
// register before it is offered.
// depends on mhfs_pkg, mhfs_in_if, mhfs_out_if, mhfs_front, mhfs_queue, mhfs_back
module mail_header_field_splitter (
  input  logic        clk,
  input  logic        rst,
  mhfs_in_if.sink     hdr_in,
  mhfs_out_if.source  res_out
);

  logic             push;
  logic             push_ready;
  mhfs_pkg::entry_t push_entry;
  logic             pop;
  logic             pop_valid;
  mhfs_pkg::entry_t pop_entry;

  // line parser
  mhfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hdr_in     (hdr_in),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // decoupling queue
  mhfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop)
  );

  // output stage
  mhfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .res_out   (res_out)
  );

endmodule

### rtl/mhfs_checker.sv
// mhfs_port_checker: port-level assertions on the mail header field splitter
// depends on mhfs_pkg; bound to mail_header_field_splitter below
module mhfs_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] out_byte,
  input logic       status,
  input logic       last
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(kind) && $stable(out_byte) && $stable(status)
                                && $stable(last))
    else $error("result changed while stalled");

  // only tag and body items carry a character
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == mhfs_pkg::K_END || kind == mhfs_pkg::K_STATUS) |-> out_byte == 8'h00)
    else $error("nonzero byte on mark or status");

  // status flag only on final status, which always closes its item
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status || kind == mhfs_pkg::K_STATUS) |-> kind == mhfs_pkg::K_STATUS && last)
    else $error("status item malformed");

  // a field-end mark is always followed by another result of the same item
  a_end_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == mhfs_pkg::K_END |-> !last)
    else $error("field end marked last");

endmodule

bind mail_header_field_splitter mhfs_port_checker u_mhfs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .kind      (res_out.kind),
  .out_byte  (res_out.out_byte),
  .status    (res_out.status),
  .last      (res_out.last)
);

### test/mhfs_checker.sv
// mhfs_checker: watches both channels of the mail header field splitter,
// predicts the result items of every accepted input item and compares them
// depends on mhfs_pkg, mhfs_in_if and mhfs_out_if
module mhfs_checker (
  input  logic clk,
  input  logic rst,
  mhfs_in_if   hdr_in,
  mhfs_out_if  res_out,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted parser state
  mhfs_pkg::phase_t line_ph;
  logic             fld_open;
  logic             fmt_err;

  // result items still owed by the block, oldest first
  mhfs_pkg::result_t split_results[$];
  int                fails = 0;

  // work out the result items of one input item and queue them
  task automatic split_header_item(input logic op, input logic [7:0] c);
    mhfs_pkg::result_t res [2];
    int                n;
    n = 0;
    if (op == mhfs_pkg::OP_END) begin
      // unfinished tag or no field at all is a format error
      if (!fmt_err && (line_ph == mhfs_pkg::PH_TAG || !fld_open)) fmt_err = 1'b1;
      if (!fmt_err) begin
        res[n] = '{mhfs_pkg::K_END, 8'h00, 1'b0, 1'b0};
        n++;
      end
      res[n] = '{mhfs_pkg::K_STATUS, 8'h00, fmt_err, 1'b0};
      n++;
      line_ph  = mhfs_pkg::PH_START;
      fld_open = 1'b0;
      fmt_err  = 1'b0;
    end else if (!fmt_err && c != mhfs_pkg::CH_CR) begin
      case (line_ph)
        mhfs_pkg::PH_START: begin
          if (c == mhfs_pkg::CH_LF) begin
            // empty line, nothing to do
          end else if (c == mhfs_pkg::CH_SPACE || c == mhfs_pkg::CH_TAB) begin
            // folded line continues the open field
            if (!fld_open) begin
              fmt_err = 1'b1;
            end else begin
              res[n] = '{mhfs_pkg::K_BODY, mhfs_pkg::CH_LF, 1'b0, 1'b0};
              n++;
              res[n] = '{mhfs_pkg::K_BODY, c, 1'b0, 1'b0};
              n++;
              line_ph = mhfs_pkg::PH_BODY;
            end
          end else if (c == mhfs_pkg::CH_COLON) begin
            fmt_err = 1'b1;
          end else begin
            // new field: close the previous one first
            if (fld_open) begin
              res[n] = '{mhfs_pkg::K_END, 8'h00, 1'b0, 1'b0};
              n++;
              fld_open = 1'b0;
            end
            res[n] = '{mhfs_pkg::K_TAG, c, 1'b0, 1'b0};
            n++;
            line_ph = mhfs_pkg::PH_TAG;
          end
        end
        mhfs_pkg::PH_TAG: begin
          if (c == mhfs_pkg::CH_LF) begin
            fmt_err = 1'b1;
          end else if (c == mhfs_pkg::CH_COLON) begin
            fld_open = 1'b1;
            line_ph  = mhfs_pkg::PH_COLON;
          end else begin
            res[n] = '{mhfs_pkg::K_TAG, c, 1'b0, 1'b0};
            n++;
          end
        end
        mhfs_pkg::PH_COLON: begin
          // one space right after the colon is dropped
          if (c == mhfs_pkg::CH_LF) begin
            line_ph = mhfs_pkg::PH_START;
          end else begin
            if (c != mhfs_pkg::CH_SPACE) begin
              res[n] = '{mhfs_pkg::K_BODY, c, 1'b0, 1'b0};
              n++;
            end
            line_ph = mhfs_pkg::PH_BODY;
          end
        end
        default: begin
          if (c == mhfs_pkg::CH_LF) begin
            line_ph = mhfs_pkg::PH_START;
          end else begin
            res[n] = '{mhfs_pkg::K_BODY, c, 1'b0, 1'b0};
            n++;
          end
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      split_results.insert(split_results.size(), res[i]);
    end
  endtask

  // report one field that differs, returns 1 on a mismatch
  function automatic int field_bad(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  // compare delivered items, then predict the newly accepted one
  always @(posedge clk) begin : watch
    mhfs_pkg::result_t want;
    if (rst) begin
      split_results.delete();
      line_ph  = mhfs_pkg::PH_START;
      fld_open = 1'b0;
      fmt_err  = 1'b0;
    end else begin
      if (res_out.valid === 1'b1 && res_out.ready === 1'b1) begin
        if (split_results.size() == 0) begin
          $error("result item with nothing expected: kind %0d out_byte %0h",
                 res_out.kind, res_out.out_byte);
          fails++;
        end else begin
          want = split_results.pop_front();
          fails += field_bad("kind", 8'(want.kind), 8'(res_out.kind));
          fails += field_bad("out_byte", want.out_byte, res_out.out_byte);
          fails += field_bad("status", 8'(want.status), 8'(res_out.status));
          fails += field_bad("last", 8'(want.last), 8'(res_out.last));
        end
      end
      if (hdr_in.valid === 1'b1 && hdr_in.ready === 1'b1)
        split_header_item(hdr_in.op, hdr_in.in_byte);
    end
    fail_count  <= fails;
    outstanding <= split_results.size();
  end

endmodule

### test/tb_top.sv
// tb_top: stimulus and verdict for the mail header field splitter
// depends on mhfs_pkg, mhfs_in_if, mhfs_out_if, mail_header_field_splitter, mhfs_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;

  mhfs_in_if  hdr_in ();
  mhfs_out_if res_out ();

  mail_header_field_splitter dut (
    .clk     (clk),
    .rst     (rst),
    .hdr_in  (hdr_in),
    .res_out (res_out)
  );

  mhfs_checker chk (
    .clk         (clk),
    .rst         (rst),
    .hdr_in      (hdr_in),
    .res_out     (res_out),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // opening items: every special case once, {op, in_byte}
  localparam logic [8:0] DIRECTED_TEXT [25] = '{
    // end with no field at all, byte at its top value
    {mhfs_pkg::OP_END, 8'hFF},
    // colon at line start, later bytes swallowed by the sticky error
    {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_COLON}, {mhfs_pkg::OP_BYTE, 8'h61},
    {mhfs_pkg::OP_END, 8'h00},
    // continuation with no open field
    {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_SPACE}, {mhfs_pkg::OP_END, 8'h00},
    // newline while still in the tag
    {mhfs_pkg::OP_BYTE, 8'h61}, {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_LF},
    {mhfs_pkg::OP_END, 8'h00},
    // end item while still in the tag
    {mhfs_pkg::OP_BYTE, 8'h61}, {mhfs_pkg::OP_END, 8'h00},
    // zero byte tag, dropped space, cr, empty line, tab continuation
    {mhfs_pkg::OP_BYTE, 8'h00}, {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_COLON},
    {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_SPACE}, {mhfs_pkg::OP_BYTE, 8'hFF},
    {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_CR}, {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_LF},
    {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_LF}, {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_TAB},
    {mhfs_pkg::OP_BYTE, 8'h78}, {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_LF},
    // second field keeps the tab after its colon
    {mhfs_pkg::OP_BYTE, 8'h62}, {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_COLON},
    {mhfs_pkg::OP_BYTE, mhfs_pkg::CH_TAB}, {mhfs_pkg::OP_END, 8'h00}
  };

  logic [8:0] stim_q[$];
  int         burst_left = 0;
  int         sent = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // append one item to the stimulus queue
  task automatic queue_item(input logic op, input logic [7:0] b);
    stim_q.insert(stim_q.size(), {op, b});
  endtask

  // printable text mostly, with blanks, cr and any byte mixed in
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: b = 8'($urandom_range(8'h21, 8'h7E));
      6: b = mhfs_pkg::CH_SPACE;
      7: b = mhfs_pkg::CH_TAB;
      8: b = mhfs_pkg::CH_CR;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // bytes that upset the line structure
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: b = mhfs_pkg::CH_LF;
      1: b = mhfs_pkg::CH_COLON;
      2: b = mhfs_pkg::CH_SPACE;
      3: b = mhfs_pkg::CH_TAB;
      4: b = mhfs_pkg::CH_CR;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // one header block of well-formed fields, now and then corrupted
  task automatic build_header_block();
    int         nfields;
    logic       last_field;
    logic [7:0] b;
    nfields = $urandom_range(1, 4);
    for (int f = 0; f < nfields; f++) begin
      last_field = (f == nfields - 1);
      if ($urandom_range(0, 7) == 0) queue_item(mhfs_pkg::OP_BYTE, mhfs_pkg::CH_LF);
      // tag, first byte must not look like a continuation
      do b = text_byte();
      while (b inside {mhfs_pkg::CH_LF, mhfs_pkg::CH_COLON, mhfs_pkg::CH_SPACE,
                       mhfs_pkg::CH_TAB, mhfs_pkg::CH_CR});
      queue_item(mhfs_pkg::OP_BYTE, b);
      repeat ($urandom_range(0, 5)) begin
        do b = text_byte(); while (b inside {mhfs_pkg::CH_LF, mhfs_pkg::CH_COLON});
        queue_item(mhfs_pkg::OP_BYTE, b);
      end
      queue_item(mhfs_pkg::OP_BYTE, mhfs_pkg::CH_COLON);
      if ($urandom_range(0, 1) == 1) queue_item(mhfs_pkg::OP_BYTE, mhfs_pkg::CH_SPACE);
      repeat ($urandom_range(0, 8)) begin
        do b = text_byte(); while (b == mhfs_pkg::CH_LF);
        queue_item(mhfs_pkg::OP_BYTE, b);
      end
      // folded lines
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 3) == 0) queue_item(mhfs_pkg::OP_BYTE, mhfs_pkg::CH_CR);
        queue_item(mhfs_pkg::OP_BYTE, mhfs_pkg::CH_LF);
        queue_item(mhfs_pkg::OP_BYTE,
                   ($urandom_range(0, 1) == 1) ? mhfs_pkg::CH_SPACE : mhfs_pkg::CH_TAB);
        repeat ($urandom_range(0, 6)) begin
          do b = text_byte(); while (b == mhfs_pkg::CH_LF);
          queue_item(mhfs_pkg::OP_BYTE, b);
        end
      end
      // line end, sometimes left open before the end item
      if (!last_field || $urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 3) == 0) queue_item(mhfs_pkg::OP_BYTE, mhfs_pkg::CH_CR);
        queue_item(mhfs_pkg::OP_BYTE, mhfs_pkg::CH_LF);
      end
    end
    // break the block in one place
    if ($urandom_range(0, 6) == 0)
      stim_q[$urandom_range(0, stim_q.size() - 1)] =
        {($urandom_range(0, 3) == 0) ? mhfs_pkg::OP_END : mhfs_pkg::OP_BYTE, noise_byte()};
    queue_item(mhfs_pkg::OP_END, 8'($urandom_range(0, 255)));
  endtask

  // offer one item in bursts with random gaps, return once accepted
  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: gap = 0;
        4, 5, 6: gap = $urandom_range(1, 6);
        default: gap = $urandom_range(7, 30);
      endcase
      if (gap > 0) begin
        hdr_in.valid   <= 1'b0;
        hdr_in.in_byte <= 8'($urandom_range(0, 255));
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    hdr_in.valid   <= 1'b1;
    hdr_in.op      <= op;
    hdr_in.in_byte <= b;
    @(posedge clk);
    while (hdr_in.ready !== 1'b1) @(posedge clk);
    sent++;
  endtask

  // sender side, then the verdict
  initial begin : stimulus
    logic [8:0] item;
    hdr_in.valid   = 1'b0;
    hdr_in.op      = mhfs_pkg::OP_BYTE;
    hdr_in.in_byte = 8'h00;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_TEXT[i]) send_item(DIRECTED_TEXT[i][8], DIRECTED_TEXT[i][7:0]);

    while (sent < 1100) begin
      if ($urandom_range(0, 9) == 0) begin
        // pure noise block
        repeat ($urandom_range(1, 16)) queue_item(mhfs_pkg::OP_BYTE, noise_byte());
        queue_item(mhfs_pkg::OP_END, 8'($urandom_range(0, 255)));
      end else begin
        build_header_block();
      end
      while (stim_q.size() > 0) begin
        item = stim_q.pop_front();
        send_item(item[8], item[7:0]);
      end
    end

    // drain the block
    hdr_in.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("mail_header_field_splitter: match");
    end else begin
      $display("mail_header_field_splitter: mismatch");
    end
    $finish;
  end

  // receiver side: changing stall patterns and two long hold-offs
  initial begin : result_sink
    int cyc;
    int mode;
    res_out.ready = 1'b0;
    cyc  = 0;
    mode = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // long hold-off so the queue fills and the input stalls
      if (cyc == 400 || cyc == 2600) begin
        res_out.ready <= 1'b0;
        repeat (300) @(posedge clk);
        cyc += 300;
      end
      if (cyc % 48 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: res_out.ready <= 1'b1;
        1: res_out.ready <= 1'($urandom_range(0, 1));
        2: res_out.ready <= ($urandom_range(0, 3) == 0);
        default: res_out.ready <= (cyc % 5 > 1);
      endcase
      @(posedge clk);
      cyc++;
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("mail_header_field_splitter: mismatch");
    $finish;
  end

endmodule
